// ===== rtl/ilid_pkg.sv =====
// shared types and constants for the indexed list
package ilid_pkg;

  localparam int CNT_W = 7;
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_ROTATE = 3'd4
  } cell_op_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  last_pos;
  } cell_ctl_t;

endpackage

// ===== rtl/indexed_list_insert_delete.sv =====
// top level of the indexed list: command decode, dump sequencer and cell chain
//
// Ordered list of signed 32-bit values held in a chain of DEPTH cells, one
// entry per cell. Clear, insert, update and delete each take one item: every
// cell looks at the broadcast command and takes its own value, its left
// neighbor, its right neighbor or the new value, so a whole shift happens
// at once. Each such item gives exactly one result, which is on the output
// the cycle after the item is taken. A dump of a list of N entries gives N
// results, one per cycle while the output is not stalled; they are sent
// from the dump state entered once the item is taken: for each result the
// head cell is sent out and the chain rotates its live part left by one, so
// after N results the list is back in place. No new item is taken while a
// dump runs; an empty list dumps as one 'empty' result. The output sits in
// a single register, so a new item is taken in the same cycle that the
// previous result leaves, but never while a stalled result still waits
// there. capacity_limit (reset 64) is written through cfg_wr_en/cfg_wr_data
// and is capped at DEPTH; a limit of zero refuses every insert.
module indexed_list_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_command,
  input  logic [6:0]          in_position,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [5:0]          out_index,
  output logic signed [31:0]  out_entry_value,
  output logic [6:0]          out_count,
  output logic                out_last
);
  import ilid_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RST = 7'd64;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   dump_idx_r, dump_idx_nxt;
  logic               out_valid_r;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_index_r, out_index_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_load;

  logic               slot_free;
  logic               in_accept;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   last_pos;
  cell_ctl_t          ctl;
  logic [VAL_W-1:0]   cell_data [DEPTH];

  // output register can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == S_DUMP) || !slot_free;
  assign in_accept = in_valid && !in_stall;

  // effective limit never exceeds the number of cells
  assign lim      = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign last_pos = count_r - 7'd1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_index_nxt  = '0;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b1;
    ctl.op         = OP_HOLD;
    ctl.pos        = in_position;
    ctl.value      = in_value;
    ctl.last_pos   = last_pos;

    if (state_r == S_DUMP) begin
      // stream the head cell and turn the live part of the chain
      if (slot_free) begin
        out_load       = 1'b1;
        out_index_nxt  = dump_idx_r;
        out_value_nxt  = cell_data[0];
        out_last_nxt   = ({1'b0, dump_idx_r} == last_pos);
        ctl.op         = OP_ROTATE;
        dump_idx_nxt   = dump_idx_r + 6'd1;
        if (out_last_nxt) begin
          state_nxt = S_IDLE;
        end
      end
    end else if (in_accept) begin
      out_load = 1'b1;
      unique case (in_command)
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        CMD_INSERT: begin
          // full is reported before the position is checked
          if (count_r >= lim) begin
            out_status_nxt = ST_FULL;
          end else if (in_position > count_r) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            ctl.op    = OP_INSERT;
            count_nxt = count_r + 7'd1;
          end
        end
        CMD_UPDATE: begin
          if (in_position >= count_r) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            ctl.op = OP_UPDATE;
          end
        end
        CMD_DELETE: begin
          if (in_position >= count_r) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            ctl.op    = OP_DELETE;
            count_nxt = count_r - 7'd1;
          end
        end
        CMD_DUMP: begin
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            // results come from the dump sequencer instead
            out_load     = 1'b0;
            state_nxt    = S_DUMP;
            dump_idx_nxt = '0;
          end
        end
        default: begin
          // unknown command leaves everything alone, one ok result
          out_status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RST;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      dump_idx_r <= dump_idx_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= out_status_nxt;
        out_index_r  <= out_index_nxt;
        out_value_r  <= out_value_nxt;
        out_last_r   <= out_last_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // count after the command travels with each result; it only changes on
  // an accepted item, so the registered count is right for every dump result
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= count_nxt;
    end
  end

  // chain of cells, neighbors wired left and right, head wraps to the tail of the live part
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ilid_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .wrap_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_index       = out_index_r;
  assign out_entry_value = out_value_r;
  assign out_count       = out_count_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/ilid_cell.sv =====
// one storage cell of the list chain
module ilid_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  ilid_pkg::cell_ctl_t       ctl,
  input  logic [ilid_pkg::VAL_W-1:0] left_data,
  input  logic [ilid_pkg::VAL_W-1:0] right_data,
  input  logic [ilid_pkg::VAL_W-1:0] wrap_data,
  output logic [ilid_pkg::VAL_W-1:0] data
);
  import ilid_pkg::*;

  localparam logic [CNT_W-1:0] K = CNT_W'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (K == ctl.pos) begin
          data_nxt = ctl.value;
        end else if (K > ctl.pos) begin
          data_nxt = left_data;
        end
      end
      OP_UPDATE: begin
        if (K == ctl.pos) begin
          data_nxt = ctl.value;
        end
      end
      OP_DELETE: begin
        if (K >= ctl.pos) begin
          data_nxt = right_data;
        end
      end
      OP_ROTATE: begin
        // live part of the chain turns left by one, head wraps to the tail
        if (K == ctl.last_pos) begin
          data_nxt = wrap_data;
        end else if (K < ctl.last_pos) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the indexed list insert/delete block
module tb;
  import ilid_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int LONG_HOLD = 300;        // receiver hold-off that backs the block up
  localparam int HOLD_AT = 60;           // accepted items before the hold-off starts
  localparam int DRAIN_CYCLES = 8;       // quiet cycles before a config write and at the end
  localparam int MAX_PRINTED = 40;

  // one command item as it goes into the block
  typedef struct packed {
    logic [2:0]              command;
    logic [CNT_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } list_cmd_t;

  // one result item as it comes out of the block
  typedef struct packed {
    status_t                 status;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } list_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [6:0] in_position = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_index;
  logic signed [31:0] out_entry_value;
  logic [6:0] out_count;
  logic out_last;

  indexed_list_insert_delete #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_index      (out_index),
    .out_entry_value(out_entry_value),
    .out_count      (out_count),
    .out_last       (out_last)
  );

  // items waiting for the driver, and results the list should still produce
  list_cmd_t    cmd_backlog[$];
  list_result_t expected_list_results[$];

  // predicted contents of the list, updated as each item is accepted
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int                      list_count = 0;
  logic [6:0]              cap_limit = 7'd64;

  // what the stimulus generator expects the count to be once its items are in
  int plan_count = 0;
  int plan_limit = LIST_DEPTH;

  int error_count = 0;
  int accepted_items = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_mode = 0;
  int recv_mode = 0;
  int mode_timer = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  list_cmd_t in_flight;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR: %s", msg);
    error_count++;
  endtask

  // gap length for either side: none, a few short ones, or busy with some long ones
  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return 0;
      1: return (r < 20) ? $urandom_range(1, 3) : 0;
      default: begin
        if (r < 8) return $urandom_range(10, 40);
        if (r < 50) return $urandom_range(1, 4);
        return 0;
      end
    endcase
  endfunction

  // apply one accepted item to the predicted list and queue up its results
  task automatic apply_list_cmd(input list_cmd_t c);
    list_result_t r;
    int eff_limit;
    int pos;
    eff_limit = (cap_limit > LIST_DEPTH) ? LIST_DEPTH : int'(cap_limit);
    pos = int'(c.position);
    r.status = ST_OK;
    r.index = '0;
    r.entry_value = '0;
    r.last = 1'b1;
    case (c.command)
      CMD_CLEAR: list_count = 0;
      CMD_INSERT: begin
        // a full list wins over a bad position
        if (list_count >= eff_limit) begin
          r.status = ST_FULL;
        end else if (pos > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = c.value;
          list_count++;
        end
      end
      CMD_UPDATE: begin
        if (pos >= list_count) r.status = ST_BADPOS;
        else list_mem[pos] = c.value;
      end
      CMD_DELETE: begin
        if (pos >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end
      end
      CMD_DUMP: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // one item per live entry, last flag on the final one
          for (int i = 0; i < list_count; i++) begin
            r.index = IDX_W'(i);
            r.entry_value = list_mem[i];
            r.count = CNT_W'(list_count);
            r.last = (i + 1 == list_count);
            expected_list_results.push_back(r);
          end
          return;
        end
      end
      default: ;  // unknown codes leave the list alone
    endcase
    r.count = CNT_W'(list_count);
    expected_list_results.push_back(r);
  endtask

  // queue an item and track where the count will end up
  task automatic plan_cmd(input logic [2:0] cmd, input int pos, input logic [31:0] val);
    list_cmd_t c;
    c.command = cmd;
    c.position = CNT_W'(pos);
    c.value = val;
    case (cmd)
      CMD_CLEAR: plan_count = 0;
      CMD_INSERT: if (plan_count < plan_limit && pos <= plan_count) plan_count++;
      CMD_DELETE: if (pos < plan_count) plan_count--;
      default: ;
    endcase
    cmd_backlog.push_back(c);
  endtask

  // random mix, mostly legal edits with random content, some bad positions and noise
  task automatic plan_random(input int n);
    int made;
    int r;
    int pos;
    logic [2:0] cmd;
    logic [31:0] val;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'h0000_0000;
          default: val = 32'hffff_ffff;
        endcase
      end else begin
        val = $urandom;
      end
      pos = $urandom_range(0, 127);
      if (r < 40) begin
        cmd = CMD_INSERT;
        pos = $urandom_range(0, plan_count);
      end else if (r < 80) begin
        cmd = (r < 55) ? CMD_UPDATE : CMD_DELETE;
        pos = (plan_count == 0) ? 0 : $urandom_range(0, plan_count - 1);
      end else if (r < 89) begin
        cmd = CMD_DUMP;
      end else if (r < 92) begin
        cmd = CMD_CLEAR;
      end else if (r < 95) begin
        cmd = 3'($urandom_range(5, 7));  // unknown code, ignored by the block
      end else begin
        // out-of-range position on an edit
        case ($urandom_range(0, 2))
          0: cmd = CMD_INSERT;
          1: cmd = CMD_UPDATE;
          default: cmd = CMD_DELETE;
        endcase
        pos = $urandom_range(plan_count + (cmd == CMD_INSERT), 127);
      end
      plan_cmd(cmd, pos, val);
      if (cmd <= CMD_DUMP) made++;
    end
  endtask

  // wait until every item is in and every result is out, then let the block settle
  task automatic wait_list_idle();
    while (cmd_backlog.size() != 0 || in_valid || expected_list_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] lim);
    wait_list_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_limit = lim;
    plan_limit = (lim > LIST_DEPTH) ? LIST_DEPTH : int'(lim);
  endtask

  // driver: one item at a time from the backlog, with random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_list_cmd(in_flight);
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || cmd_backlog.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_flight = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_command <= in_flight.command;
          in_position <= in_flight.position;
          in_value <= in_flight.value;
          send_gap = pick_gap(send_mode);
        end
      end
    end
  end

  // monitor: check each result item against the oldest expectation, stall at random
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.index = out_index;
        got.entry_value = out_entry_value;
        got.count = out_count;
        got.last = out_last;
        if (expected_list_results.size() == 0) begin
          report_error($sformatf("result item with none expected: status %0d index %0d",
                                 got.status, got.index));
        end else begin
          want = expected_list_results.pop_front();
          if (got.status !== want.status)
            report_error($sformatf("status: expected %0d got %0d", want.status, got.status));
          if (got.index !== want.index)
            report_error($sformatf("index: expected %0d got %0d", want.index, got.index));
          if (got.entry_value !== want.entry_value)
            report_error($sformatf("entry_value: expected %0d got %0d",
                                   want.entry_value, got.entry_value));
          if (got.count !== want.count)
            report_error($sformatf("count: expected %0d got %0d", want.count, got.count));
          if (got.last !== want.last)
            report_error($sformatf("last: expected %0d got %0d at index %0d",
                                   want.last, got.last, want.index));
        end
      end
      // long hold-off wins over the ordinary random stalls
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else begin
        out_stall <= 1'b0;
        recv_gap = pick_gap(recv_mode);
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering items
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_items >= HOLD_AT) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // re-roll how busy each side is every so often, so quiet stretches show up too
  always @(posedge clk) begin
    if (mode_timer == 149) begin
      mode_timer <= 0;
      send_mode <= $urandom_range(0, 2);
      recv_mode <= $urandom_range(0, 2);
    end else begin
      mode_timer <= mode_timer + 1;
    end
  end

  // watchdog: too long with no item moving means the block is hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mid_limit;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases at the reset limit
    plan_cmd(CMD_DUMP, 0, 32'd0);
    plan_cmd(CMD_DELETE, 0, 32'd0);
    plan_cmd(CMD_INSERT, 1, 32'd5);
    // build a short list: append, head and middle inserts with extreme values
    plan_cmd(CMD_INSERT, 0, 32'h8000_0000);
    plan_cmd(CMD_INSERT, 1, 32'h7fff_ffff);
    plan_cmd(CMD_INSERT, 0, 32'hffff_ffff);
    plan_cmd(CMD_INSERT, 1, 32'h0000_0000);
    plan_cmd(CMD_UPDATE, 3, 32'h1234_5678);
    plan_cmd(CMD_UPDATE, 4, 32'hdead_beef);
    plan_cmd(CMD_INSERT, 127, 32'h5555_aaaa);
    plan_cmd(CMD_DUMP, 0, 32'd0);
    // delete from the middle and the tail, then one past the end
    plan_cmd(CMD_DELETE, 1, 32'd0);
    plan_cmd(CMD_DELETE, 2, 32'd0);
    plan_cmd(CMD_DELETE, 2, 32'd0);
    // unknown codes are ignored
    plan_cmd(3'd5, 127, 32'hffff_ffff);
    plan_cmd(3'd7, 64, 32'h0f0f_0f0f);
    plan_cmd(CMD_DUMP, 0, 32'd0);
    plan_cmd(CMD_CLEAR, 0, 32'd0);
    plan_cmd(CMD_DUMP, 0, 32'd0);
    plan_cmd(CMD_INSERT, 0, 32'd42);

    // limit of one: list is full, and full is reported before a bad position
    set_capacity(7'd1);
    plan_cmd(CMD_INSERT, 0, 32'd7);
    plan_cmd(CMD_INSERT, 9, 32'd7);

    // limit of zero refuses every insert, even on an empty list
    set_capacity(7'd0);
    plan_cmd(CMD_INSERT, 0, 32'd8);
    plan_cmd(CMD_DELETE, 0, 32'd0);
    plan_cmd(CMD_INSERT, 0, 32'd9);
    plan_cmd(CMD_DUMP, 0, 32'd0);

    // limit above the depth saturates to the depth; a random phase runs at it
    set_capacity(7'd127);
    plan_random(75);

    set_capacity(7'd3);
    plan_random(70);

    set_capacity(7'd64);
    plan_random(70);

    mid_limit = $urandom_range(4, 63);
    set_capacity(7'(mid_limit));
    plan_random(70);

    set_capacity(7'd100);
    plan_random(70);

    wait_list_idle();
    if (error_count == 0 && expected_list_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ilid_pkg.sv
rtl/ilid_cell.sv
rtl/indexed_list_insert_delete.sv
tb/tb.sv
